FILE: rtl/ictf_pkg.sv
// package for the complementary tilt filter: item types, sequencer states,
// cordic angle table and register map. no dependencies
package ictf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int STATE_FRAC_BITS_DEF = 12;
  localparam int ANG_W               = 34;
  localparam int ANG_FRAC            = 24;
  localparam int CFG_AW              = 4;
  localparam int CFG_DW              = 32;
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;
  localparam logic signed [ANG_W-1:0] ANG_180 = 34'sd3019898880;

  typedef enum logic [1:0] {
    REG_BLEND_ALPHA   = 2'd0,
    REG_RATE_OFFSET_X = 2'd1,
    REG_RATE_OFFSET_Y = 2'd2,
    REG_RATE_OFFSET_Z = 2'd3
  } ictf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_CONV,
    ST_MUL,
    ST_BLEND,
    ST_DONE
  } ictf_state_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } out_item_t;

  // round(atan(2^-i) deg * 2^24)
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ictf_stream_if.sv
// valid/ready channel carrying one item of type T
// no dependencies; T is set from ictf_pkg types by the user
interface ictf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/imu_complementary_tilt_filter_core.sv
// complementary tilt filter core: three cordic atan2 runs blended with gyro
// integration. depends on ictf_pkg and ictf_stream_if
//
// One item runs through a single shared cordic shift-add unit that handles
// the three angles one after another, followed by one shared multiplier for
// each blend. The block takes no new item while an item is in work; the
// result waits in an output register, and a new item is taken once the
// result has gone into it, which waits until an earlier result there is taken.
// Registers sit at byte addresses 0, 4, 8, 12: blend_alpha (Q16, values above
// one act as one), then the x, y and z gyro offsets. Angles are in 1/128 deg.
module imu_complementary_tilt_filter_core #(
  parameter int CORDIC_STEPS    = ictf_pkg::CORDIC_STEPS_DEF,
  parameter int STATE_FRAC_BITS = ictf_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ictf_stream_if.sink                 in_if,
  ictf_stream_if.source               out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ictf_pkg::CFG_AW-1:0] paddr,
  input  logic [ictf_pkg::CFG_DW-1:0] pwdata,
  output logic [ictf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ictf_pkg::*;

  localparam int F    = STATE_FRAC_BITS;
  localparam int SW   = F + 10;
  localparam int DW   = SW + 1;
  localparam int PW   = DW + 18;
  localparam int CW   = 28;
  localparam int IW   = $clog2(CORDIC_STEPS);
  localparam int AS   = ANG_FRAC - F;
  localparam int IRW  = F + 23;
  localparam int OW   = SW + 1;
  localparam logic signed [ANG_W-1:0] ZRND = ANG_W'(64'd1 << (AS - 1));
  localparam logic signed [OW-1:0]    ORND = OW'((64'd1 << (F - 7)) >> 1);
  localparam logic signed [DW:0]      LIM  = (DW+1)'(64'd256 << F);
  localparam logic [IW-1:0]           ILAST = IW'(CORDIC_STEPS - 1);

  // configuration
  logic [16:0]        alpha_r;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 17'd3277;
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_wr) begin
      case (ictf_reg_t'(paddr[3:2]))
        REG_BLEND_ALPHA:   alpha_r <= pwdata[16:0];
        REG_RATE_OFFSET_X: off_x_r <= pwdata[15:0];
        REG_RATE_OFFSET_Y: off_y_r <= pwdata[15:0];
        REG_RATE_OFFSET_Z: off_z_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ictf_reg_t'(paddr[3:2]))
      REG_BLEND_ALPHA:   prdata = {15'd0, alpha_r};
      REG_RATE_OFFSET_X: prdata = {{16{off_x_r[15]}}, off_x_r};
      REG_RATE_OFFSET_Y: prdata = {{16{off_y_r[15]}}, off_y_r};
      REG_RATE_OFFSET_Z: prdata = {{16{off_z_r[15]}}, off_z_r};
      default:           prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  ictf_state_t state_r, state_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [IW-1:0] i_r, i_nxt;
  in_item_t    item_r, item_nxt;
  logic signed [CW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic        zero_r, zero_nxt;
  logic signed [SW-1:0] b_r, b_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic signed [PW-1:0] p_r, p_nxt;
  logic signed [SW-1:0] ang_r [3];
  logic signed [SW-1:0] ang_nxt;
  logic        ang_we;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic signed [15:0] sel_y, sel_x, sel_rate, sel_off;
  logic signed [SW-1:0] prev;

  always_comb begin
    case (k_r)
      2'd0: begin
        sel_y = item_r.accel_x; sel_x = item_r.accel_z;
        sel_rate = item_r.rate_y; sel_off = off_y_r;
      end
      2'd1: begin
        sel_y = item_r.accel_y; sel_x = item_r.accel_z;
        sel_rate = item_r.rate_x; sel_off = off_x_r;
      end
      default: begin
        sel_y = item_r.accel_y; sel_x = item_r.accel_x;
        sel_rate = item_r.rate_z; sel_off = off_z_r;
      end
    endcase
  end

  assign prev = ang_r[k_r];
  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_if.valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ITER;
      ST_ITER:  if (i_r == ILAST) state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = (k_r == 2'd2) ? ST_DONE : ST_LOAD;
      ST_DONE:  if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  function automatic logic signed [15:0] to_out(input logic signed [SW-1:0] s);
    logic signed [OW-1:0] t;
    t = (OW'(s) + ORND) >>> (F - 7);
    if (t > OW'(32767))       to_out = 16'sh7fff;
    else if (t < -OW'(32768)) to_out = 16'sh8000;
    else                      to_out = t[15:0];
  endfunction

  logic signed [CW-1:0]    ld_x, ld_y, xs, ys;
  logic signed [ANG_W-1:0] zsel, acc_w;
  logic signed [16:0]      rr;
  logic signed [21:0]      r25;
  logic signed [IRW-1:0]   incw;
  logic signed [SW-1:0]    acc, inc, bsum;
  logic signed [PW-1:0]    pr;
  logic signed [DW:0]      v;

  // datapath
  always_comb begin
    k_nxt = k_r;
    i_nxt = i_r;
    item_nxt = item_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    zero_nxt = zero_r;
    b_nxt = b_r;
    d_nxt = d_r;
    p_nxt = p_r;
    ang_we = 1'b0;
    ang_nxt = prev;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_data_nxt = out_data_r;

    ld_y = CW'($signed({sel_y, 8'd0}));
    ld_x = CW'($signed({sel_x, 8'd0}));
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    zsel = zero_r ? '0 : z_r;
    acc_w = (-zsel + ZRND) >>> AS;
    acc = acc_w[SW-1:0];
    rr = 17'(sel_rate) + 17'(sel_off);
    r25 = (22'(rr) <<< 4) + (22'(rr) <<< 3) + 22'(rr);
    incw = ((IRW'(r25)) <<< F) + IRW'(8192);
    inc = SW'(incw >>> 14);
    bsum = prev + inc;
    pr = (p_r + PW'(32768)) >>> 16;
    v = (DW+1)'(b_r) + pr[DW:0];

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          item_nxt = in_if.data;
          k_nxt = 2'd0;
        end
      end
      ST_LOAD: begin
        i_nxt = '0;
        zero_nxt = (sel_x == 16'sd0) && (sel_y == 16'sd0);
        if (sel_x < 16'sd0) begin
          x_nxt = -ld_x;
          y_nxt = -ld_y;
          z_nxt = (sel_y >= 16'sd0) ? ANG_180 : -ANG_180;
        end else begin
          x_nxt = ld_x;
          y_nxt = ld_y;
          z_nxt = '0;
        end
      end
      ST_ITER: begin
        if (y_r < 0) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_deg(5'(i_r));
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_deg(5'(i_r));
        end
        i_nxt = i_r + 1'b1;
      end
      ST_CONV: begin
        b_nxt = bsum;
        d_nxt = DW'(acc) - DW'(bsum);
      end
      ST_MUL: begin
        p_nxt = PW'($signed({1'b0, (alpha_r[16] ? ALPHA_ONE : alpha_r)}) * d_r);
      end
      ST_BLEND: begin
        ang_we = 1'b1;
        if (v > LIM)       ang_nxt = SW'(LIM);
        else if (v < -LIM) ang_nxt = SW'(-LIM);
        else               ang_nxt = v[SW-1:0];
        k_nxt = k_r + 2'd1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.roll_angle  = to_out(ang_r[0]);
          out_data_nxt.pitch_angle = to_out(ang_r[1]);
          out_data_nxt.yaw_angle   = to_out(ang_r[2]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r <= '0;
      i_r <= '0;
      out_valid_r <= 1'b0;
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
      out_valid_r <= out_valid_nxt;
      if (ang_we) ang_r[k_r] <= ang_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    zero_r <= zero_nxt;
    b_r <= b_nxt;
    d_r <= d_nxt;
    p_r <= p_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
